// ===== sv/pcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbp_pkg: shared types and constants of the prefix code bit packer
// Holds table sizes, field widths, request codes and the command record
// passed from the lookup front end to the bit shifting back end.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  // table and code sizes
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
  localparam int SYM_AW       = $clog2(SYMBOL_COUNT);

  // field widths
  localparam int FUNC_W    = 2;
  localparam int SYMBOL_W  = 8;
  localparam int LEN_IN_W  = 6;
  localparam int CODE_W    = 32;
  localparam int LENM1_W   = 5;
  localparam int BYTE_W    = 8;
  localparam int ACC_W     = 7;
  localparam int CNT_W     = 3;
  localparam int REM_W     = 6;
  localparam int STEP_W    = 4;
  localparam int IN_DATA_W = 48;
  localparam int ENTRY_W   = CODE_W + LENM1_W;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request codes on the input stream
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } pcbp_func_e;

  // work kinds handed to the back end
  typedef enum logic [1:0] {
    KIND_ENCODE,
    KIND_FLUSH,
    KIND_UNKNOWN
  } pcbp_kind_e;

  // back end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } pcbp_state_e;

  // one queued command
  typedef struct packed {
    pcbp_kind_e                kind;
    logic [LENM1_W-1:0]        len_m1;
    logic [CODE_W-1:0]         code;
  } pcbp_cmd_t;

endpackage

// ===== sv/pcbp_front.sv =====
// ----------------------------------------------------------------------------
// pcbp_front: request intake and code table lookup
// Writes loaded codes into the table, looks up symbols to encode and hands
// encode, flush and unknown-symbol commands to the command queue.
// ----------------------------------------------------------------------------
module pcbp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [pcbp_pkg::FUNC_W-1:0]  func_i,
  input  logic [pcbp_pkg::SYMBOL_W-1:0] symbol_i,
  input  logic [pcbp_pkg::LEN_IN_W-1:0] code_length_i,
  input  logic [pcbp_pkg::CODE_W-1:0]  code_bits_i,
  output logic                         cmd_valid_o,
  output pcbp_pkg::pcbp_cmd_t          cmd_o,
  input  logic                         cmd_ready_i
);
  import pcbp_pkg::*;

  logic [ENTRY_W-1:0]      code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] entry_valid_q;
  logic [ENTRY_W-1:0]      rd_data_q;
  logic                    stage_valid_q;
  pcbp_kind_e              stage_kind_q;
  logic                    accept;
  logic                    in_table;
  logic                    sym_known;
  logic                    load_we;
  logic [SYM_AW-1:0]       sym_idx;
  logic [LENM1_W-1:0]      len_m1;

  // intake handshake: stage register frees when the queue takes it
  assign req_ready_o = !stage_valid_q || cmd_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  // symbol range and valid mark
  assign in_table  = {1'b0, symbol_i} < (SYMBOL_W + 1)'(SYMBOL_COUNT);
  assign sym_idx   = symbol_i[SYM_AW-1:0];
  assign sym_known = in_table && entry_valid_q[sym_idx];
  assign load_we   = accept && (func_i == FUNC_LOAD) && in_table;

  // code length clamped to 1..LEN_LIMIT, stored minus one
  always_comb begin
    if (code_length_i == '0) begin
      len_m1 = '0;
    end else if (code_length_i > LEN_IN_W'(LEN_LIMIT)) begin
      len_m1 = LENM1_W'(LEN_LIMIT - 1);
    end else begin
      len_m1 = LENM1_W'(code_length_i - LEN_IN_W'(1));
    end
  end

  // code table write port
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      code_mem[sym_idx] <= {len_m1, code_bits_i};
    end
  end

  // code table read port, registered
  always_ff @(posedge clk_i) begin
    if (accept && (func_i == FUNC_ENCODE)) begin
      rd_data_q <= code_mem[sym_idx];
    end
  end

  // valid marks, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
    end else if (load_we) begin
      entry_valid_q[sym_idx] <= 1'b1;
    end
  end

  // command stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      stage_kind_q  <= KIND_ENCODE;
    end else if (req_ready_o) begin
      if (accept) begin
        case (func_i)
          FUNC_ENCODE: begin
            stage_valid_q <= 1'b1;
            stage_kind_q  <= sym_known ? KIND_ENCODE : KIND_UNKNOWN;
          end
          FUNC_FLUSH: begin
            stage_valid_q <= 1'b1;
            stage_kind_q  <= KIND_FLUSH;
          end
          default: begin
            stage_valid_q <= 1'b0;
          end
        endcase
      end else begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  // command towards the queue
  assign cmd_valid_o   = stage_valid_q;
  assign cmd_o.kind    = stage_kind_q;
  assign cmd_o.len_m1  = rd_data_q[CODE_W +: LENM1_W];
  assign cmd_o.code    = rd_data_q[CODE_W-1:0];

endmodule

// ===== sv/pcbp_fifo.sv =====
// ----------------------------------------------------------------------------
// pcbp_fifo: short command queue
// Decouples table lookup from bit shifting so that either side can stall.
// ----------------------------------------------------------------------------
module pcbp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pcbp_pkg::pcbp_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output pcbp_pkg::pcbp_cmd_t pop_cmd_o,
  output logic                empty_o
);
  import pcbp_pkg::*;

  pcbp_cmd_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/pcbp_back.sv =====
// ----------------------------------------------------------------------------
// pcbp_back: bit accumulator and byte output
// Shifts code bits into the pending byte, up to one byte per cycle while the output register is free, and
// drives the output register with code bytes, final bytes and flags.
// ----------------------------------------------------------------------------
module pcbp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  pcbp_pkg::pcbp_cmd_t           cmd_i,
  output logic                          cmd_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcbp_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          out_final_o,
  output logic                          out_unknown_o
);
  import pcbp_pkg::*;

  pcbp_state_e        state_q, state_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_byte_q, out_byte_d;
  logic               out_final_q, out_final_d;
  logic               out_unknown_q, out_unknown_d;
  logic               out_free;
  logic [STEP_W-1:0]  room;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  total;
  logic [BYTE_W-1:0]  merged;
  logic [BYTE_W-1:0]  flush_byte;

  // chunk arithmetic: take as many code bits as fit in the pending byte
  assign out_free   = !out_valid_q || out_ready_i;
  assign room       = STEP_W'(BYTE_W) - STEP_W'(cnt_q);
  assign step       = (rem_q < REM_W'(room)) ? STEP_W'(rem_q) : room;
  assign total      = STEP_W'(cnt_q) + step;
  assign merged     = ({1'b0, acc_q} << step)
                    | (code_q[CODE_W-1 -: BYTE_W] >> (STEP_W'(BYTE_W) - step));
  assign flush_byte = {1'b0, acc_q} << room;

  // sequencer and output register next state
  always_comb begin
    state_d       = state_q;
    acc_d         = acc_q;
    cnt_d         = cnt_q;
    code_d        = code_q;
    rem_d         = rem_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_byte_d    = out_byte_q;
    out_final_d   = out_final_q;
    out_unknown_d = out_unknown_q;
    cmd_pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            KIND_ENCODE: begin
              cmd_pop_o = 1'b1;
              code_d    = cmd_i.code << (LENM1_W'(CODE_W - 1) - cmd_i.len_m1);
              rem_d     = REM_W'(cmd_i.len_m1) + REM_W'(1);
              state_d   = ST_SHIFT;
            end
            KIND_FLUSH: begin
              if (cnt_q == '0) begin
                cmd_pop_o = 1'b1;
              end else if (out_free) begin
                cmd_pop_o     = 1'b1;
                out_valid_d   = 1'b1;
                out_byte_d    = flush_byte;
                out_final_d   = 1'b1;
                out_unknown_d = 1'b0;
                acc_d         = '0;
                cnt_d         = '0;
              end
            end
            KIND_UNKNOWN: begin
              if (out_free) begin
                cmd_pop_o     = 1'b1;
                out_valid_d   = 1'b1;
                out_byte_d    = '0;
                out_final_d   = 1'b0;
                out_unknown_d = 1'b1;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (total == STEP_W'(BYTE_W)) begin
          // byte complete: needs a free output register
          if (out_free) begin
            out_valid_d   = 1'b1;
            out_byte_d    = merged;
            out_final_d   = 1'b0;
            out_unknown_d = 1'b0;
            acc_d         = '0;
            cnt_d         = '0;
            code_d        = code_q << step;
            rem_d         = rem_q - REM_W'(step);
            if (rem_q == REM_W'(step)) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          acc_d  = merged[ACC_W-1:0];
          cnt_d  = total[CNT_W-1:0];
          code_d = code_q << step;
          rem_d  = rem_q - REM_W'(step);
          if (rem_q == REM_W'(step)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    code_q        <= code_d;
    rem_q         <= rem_d;
    out_byte_q    <= out_byte_d;
    out_final_q   <= out_final_d;
    out_unknown_q <= out_unknown_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_final_o   = out_final_q;
  assign out_unknown_o = out_unknown_q;

endmodule

// ===== sv/prefix_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_unit: table driven prefix code encoder
// Usage: requests arrive on the s_axis channel with the request code in
// tuser: load writes one symbol's code into the table, encode appends the
// symbol's code to the bit stream, flush pads and gives any pending last byte.
// Packed bytes leave on m_axis, first code bit in bit seven; tlast marks the
// zero padded final byte of a flush, tuser marks a symbol with no code.
// A load gives nothing. An encode is looked up in the front end's
// registered table read and passes through the command queue; the shifter
// then fetches it from the queue and shifts it in chunks of up to eight bits.
// The shifter sets the sustained rate.
// Reset clears all table valid marks and empties the bit accumulator; the
// table contents themselves are only meaningful once loaded.
// When m_axis_tready is low the output register holds its byte, the shifter
// halts, the two entry command queue fills and s_axis_tready then drops.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol [7:0], code_length [13:8], code_bits [45:14]
  input  logic [1:0]  s_axis_tuser,   // func [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // symbol_unknown [0]
);
  import pcbp_pkg::*;

  logic                 front_cmd_valid;
  pcbp_cmd_t            front_cmd;
  logic                 queue_full;
  logic                 queue_empty;
  pcbp_cmd_t            queue_cmd;
  logic                 back_pop;
  logic                 out_unknown;
  logic [SYMBOL_W-1:0]  symbol;
  logic [LEN_IN_W-1:0]  code_length;
  logic [CODE_W-1:0]    code_bits;

  // request field unpacking
  assign symbol      = s_axis_tdata[SYMBOL_W-1:0];
  assign code_length = s_axis_tdata[SYMBOL_W +: LEN_IN_W];
  assign code_bits   = s_axis_tdata[SYMBOL_W + LEN_IN_W +: CODE_W];

  // lookup front end
  pcbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .func_i        (s_axis_tuser),
    .symbol_i      (symbol),
    .code_length_i (code_length),
    .code_bits_i   (code_bits),
    .cmd_valid_o   (front_cmd_valid),
    .cmd_o         (front_cmd),
    .cmd_ready_i   (!queue_full)
  );

  // command queue
  pcbp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_cmd_valid),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .pop_i      (back_pop),
    .pop_cmd_o  (queue_cmd),
    .empty_o    (queue_empty)
  );

  // shifting back end
  pcbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!queue_empty),
    .cmd_i         (queue_cmd),
    .cmd_pop_o     (back_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_final_o   (m_axis_tlast),
    .out_unknown_o (out_unknown)
  );

  assign m_axis_tuser = out_unknown;

endmodule
